### design/pnz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnz_pkg: shared types, constants and permutation ROM for 3D gradient noise
// Holds field widths, the 256-entry hash permutation and gradient codes.
// ----------------------------------------------------------------------------
package pnz_pkg;

  localparam int unsigned PNZ_FRAC_BITS = 16;
  localparam int unsigned COORD_W       = 24;
  localparam int unsigned NOISE_W       = 18;
  localparam int unsigned CELL_W        = 8;
  localparam int unsigned HASH_W        = 4;
  localparam int unsigned NUM_CORNERS   = 8;
  localparam int unsigned PIPE_LATENCY  = 11;

  localparam int NOISE_MAX = (1 <<< (NOISE_W - 1)) - 1;
  localparam int NOISE_MIN = -(1 <<< (NOISE_W - 1));

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [HASH_W-1:0] grad_t;

  // Gradient codes that pair the z row with x instead of z
  localparam grad_t GRAD_ZX_A = 4'd12;
  localparam grad_t GRAD_ZX_B = 4'd14;

  localparam cell_t CELL_ONE = 8'd1;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic cell_t perm(input cell_t idx);
    return PERM_ROM[idx];
  endfunction

endpackage
`default_nettype wire

### design/pnz_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnz_hash: three-stage corner hash pipeline
// Chains three permutation lookups to get the gradient code of each corner.
// ----------------------------------------------------------------------------
module pnz_hash (
  input  logic                                         clk_i,
  input  pnz_pkg::cell_t                               cell_x_i,
  input  pnz_pkg::cell_t                               cell_y_i,
  input  pnz_pkg::cell_t                               cell_z_i,
  output pnz_pkg::grad_t [pnz_pkg::NUM_CORNERS-1:0]    grad_o
);
  import pnz_pkg::*;

  cell_t a_d, b_d, a_q, b_q, z_q;
  cell_t aa_d, ab_d, ba_d, bb_d, aa_q, ab_q, ba_q, bb_q;
  grad_t [NUM_CORNERS-1:0] grad_d, grad_q;

  always_comb begin
    a_d  = perm(cell_x_i) + cell_y_i;
    b_d  = perm(cell_x_i + CELL_ONE) + cell_y_i;
    aa_d = perm(a_q) + z_q;
    ab_d = perm(a_q + CELL_ONE) + z_q;
    ba_d = perm(b_q) + z_q;
    bb_d = perm(b_q + CELL_ONE) + z_q;
    // corner index bits: x is bit 0, y bit 1, z bit 2
    grad_d[0] = grad_t'(perm(aa_q));
    grad_d[1] = grad_t'(perm(ba_q));
    grad_d[2] = grad_t'(perm(ab_q));
    grad_d[3] = grad_t'(perm(bb_q));
    grad_d[4] = grad_t'(perm(aa_q + CELL_ONE));
    grad_d[5] = grad_t'(perm(ba_q + CELL_ONE));
    grad_d[6] = grad_t'(perm(ab_q + CELL_ONE));
    grad_d[7] = grad_t'(perm(bb_q + CELL_ONE));
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    z_q    <= cell_z_i;
    aa_q   <= aa_d;
    ab_q   <= ab_d;
    ba_q   <= ba_d;
    bb_q   <= bb_d;
    grad_q <= grad_d;
  end

  assign grad_o = grad_q;

endmodule
`default_nettype wire

### design/pnz_fade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnz_fade: four-stage fade curve 6t^5 - 15t^4 + 10t^3
// Multiplies in stages one to three, each rounded half up to the fraction width.
// ----------------------------------------------------------------------------
module pnz_fade #(
  parameter int unsigned FRAC_BITS = pnz_pkg::PNZ_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic [FRAC_BITS-1:0]   frac_i,
  output logic [FRAC_BITS+1:0]   fade_o
);
  import pnz_pkg::*;

  localparam int unsigned FB = FRAC_BITS;
  localparam logic [FB+3:0]   K15  = (FB+4)'(15) << FB;
  localparam logic [FB+3:0]   K10  = (FB+4)'(10) << FB;
  localparam logic [2*FB+4:0] HALF = (2*FB+5)'(1) << (FB-1);

  logic [FB+3:0]   coef;
  logic [2*FB-1:0] sq_prod_d, sq_prod_q;
  logic [2*FB+3:0] neg_prod_d, neg_prod_q;
  logic [FB-1:0]   frac1_q;
  logic [2*FB:0]   sq_sum;
  logic [FB-1:0]   sq;
  logic [2*FB-1:0] cube_prod_d, cube_prod_q;
  logic [2*FB+4:0] neg_sum;
  logic [FB+3:0]   poly_d, poly_q;
  logic [2*FB:0]   cube_sum;
  logic [FB-1:0]   cube;
  logic [2*FB+3:0] mix_prod_d, mix_prod_q;
  logic [2*FB+4:0] mix_sum;
  logic [FB+1:0]   fade_d, fade_q;

  always_comb begin
    coef        = K15 - ((FB+4)'(frac_i) << 2) - ((FB+4)'(frac_i) << 1);
    sq_prod_d   = (2*FB)'(frac_i) * (2*FB)'(frac_i);
    neg_prod_d  = (2*FB+4)'(coef) * (2*FB+4)'(frac_i);

    sq_sum      = (2*FB+1)'(sq_prod_q) + (2*FB+1)'(HALF);
    sq          = sq_sum[2*FB-1:FB];
    cube_prod_d = (2*FB)'(sq) * (2*FB)'(frac1_q);
    neg_sum     = (2*FB+5)'(neg_prod_q) + HALF;
    poly_d      = K10 - neg_sum[2*FB+3:FB];

    cube_sum    = (2*FB+1)'(cube_prod_q) + (2*FB+1)'(HALF);
    cube        = cube_sum[2*FB-1:FB];
    mix_prod_d  = (2*FB+4)'(cube) * (2*FB+4)'(poly_q);

    mix_sum     = (2*FB+5)'(mix_prod_q) + HALF;
    fade_d      = mix_sum[2*FB+1:FB];
  end

  always_ff @(posedge clk_i) begin
    sq_prod_q   <= sq_prod_d;
    neg_prod_q  <= neg_prod_d;
    frac1_q     <= frac_i;
    cube_prod_q <= cube_prod_d;
    poly_q      <= poly_d;
    mix_prod_q  <= mix_prod_d;
    fade_q      <= fade_d;
  end

  assign fade_o = fade_q;

endmodule
`default_nettype wire

### design/pnz_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnz_blend: corner dot products and trilinear blend tree
// Seven stages: dots, then multiply and round-add per axis (x, y, z).
// ----------------------------------------------------------------------------
module pnz_blend #(
  parameter int unsigned FRAC_BITS = pnz_pkg::PNZ_FRAC_BITS
) (
  input  logic                                          clk_i,
  input  pnz_pkg::grad_t [pnz_pkg::NUM_CORNERS-1:0]     grad_i,
  input  logic [FRAC_BITS-1:0]                          frac_x_i,
  input  logic [FRAC_BITS-1:0]                          frac_y_i,
  input  logic [FRAC_BITS-1:0]                          frac_z_i,
  input  logic [FRAC_BITS+1:0]                          fade_x_i,
  input  logic [FRAC_BITS+1:0]                          fade_y_i,
  input  logic [FRAC_BITS+1:0]                          fade_z_i,
  output logic signed [pnz_pkg::NOISE_W-1:0]            noise_value_o
);
  import pnz_pkg::*;

  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned DW = FB + 3;   // dot product
  localparam int unsigned LW = FB + 4;   // blended level
  localparam int unsigned TW = FB + 3;   // signed fade weight
  localparam int unsigned MW = LW + 1;   // level difference
  localparam int unsigned PW = TW + MW;  // weighted difference

  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [LW-1:0] lvl_t;
  typedef logic signed [TW-1:0] wgt_t;
  typedef logic signed [MW-1:0] dif_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam dot_t  UNIT = DW'(1) << FB;
  localparam prod_t HALF = PW'(1) << (FB - 1);

  function automatic dot_t grad_dot(input grad_t h, input dot_t x, input dot_t y,
                                    input dot_t z);
    dot_t u;
    dot_t v;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      v = y;
    end else if (h == GRAD_ZX_A || h == GRAD_ZX_B) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // a + floor((p + half) / unit)
  function automatic lvl_t lerp_round(input lvl_t a, input prod_t p);
    prod_t s;
    s = (p + HALF) >>> FB;
    return a + LW'(s);
  endfunction

  dot_t  xa, xb, ya, yb, za, zb;
  dot_t  dot_d [NUM_CORNERS];
  dot_t  dot_q [NUM_CORNERS];
  wgt_t  wu, wv, ww;
  dif_t  dx [4];
  dif_t  dy [2];
  dif_t  dz;
  prod_t px_d [4];
  prod_t px_q [4];
  lvl_t  bx_q [4];
  lvl_t  lx_d [4];
  lvl_t  lx_q [4];
  prod_t py_d [2];
  prod_t py_q [2];
  lvl_t  by_q [2];
  lvl_t  ly_d [2];
  lvl_t  ly_q [2];
  prod_t pz_d, pz_q;
  lvl_t  bz_q;
  lvl_t  res;
  logic signed [31:0] res_ext;
  logic signed [NOISE_W-1:0] out_d, out_q;
  wgt_t  fv_q [2];
  wgt_t  fw_q [4];

  always_comb begin
    xa = $signed({3'b000, frac_x_i});
    ya = $signed({3'b000, frac_y_i});
    za = $signed({3'b000, frac_z_i});
    xb = xa - UNIT;
    yb = ya - UNIT;
    zb = za - UNIT;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      dot_d[c] = grad_dot(grad_i[c], (c % 2 != 0) ? xb : xa,
                          ((c / 2) % 2 != 0) ? yb : ya, (c / 4 != 0) ? zb : za);
    end

    wu = $signed({1'b0, fade_x_i});
    wv = $signed({1'b0, fade_y_i});
    ww = $signed({1'b0, fade_z_i});

    for (int i = 0; i < 4; i++) begin
      dx[i]   = MW'(dot_q[2*i+1]) - MW'(dot_q[2*i]);
      px_d[i] = PW'(wu) * PW'(dx[i]);
      lx_d[i] = lerp_round(bx_q[i], px_q[i]);
    end

    for (int j = 0; j < 2; j++) begin
      dy[j]   = MW'(lx_q[2*j+1]) - MW'(lx_q[2*j]);
      py_d[j] = PW'(fv_q[1]) * PW'(dy[j]);
      ly_d[j] = lerp_round(by_q[j], py_q[j]);
    end

    dz   = MW'(ly_q[1]) - MW'(ly_q[0]);
    pz_d = PW'(fw_q[3]) * PW'(dz);

    res     = lerp_round(bz_q, pz_q);
    res_ext = 32'(res);
    if (res_ext > NOISE_MAX) begin
      out_d = NOISE_W'(NOISE_MAX);
    end else if (res_ext < NOISE_MIN) begin
      out_d = NOISE_W'(NOISE_MIN);
    end else begin
      out_d = NOISE_W'(res_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q   <= dot_d;
    fv_q[0] <= wv;
    fv_q[1] <= fv_q[0];
    fw_q[0] <= ww;
    for (int k = 1; k < 4; k++) begin
      fw_q[k] <= fw_q[k-1];
    end
    for (int i = 0; i < 4; i++) begin
      px_q[i] <= px_d[i];
      bx_q[i] <= LW'(dot_q[2*i]);
      lx_q[i] <= lx_d[i];
    end
    for (int j = 0; j < 2; j++) begin
      py_q[j] <= py_d[j];
      by_q[j] <= lx_q[2*j];
      ly_q[j] <= ly_d[j];
    end
    pz_q  <= pz_d;
    bz_q  <= ly_q[0];
    out_q <= out_d;
  end

  assign noise_value_o = out_q;

endmodule
`default_nettype wire

### design/perlin_noise_3d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_3d: pipelined 3D improved gradient noise
// One point in, one signed noise sample out, fixed latency.
//
//   channel   ports                              direction  handshake
//   command   start_i, busy_o, coord_{x,y,z}_i   in         start_i & !busy_o
//   result    done_o, noise_value_o              out        done_o, one cycle
//
// One point is taken every clock cycle; busy_o stays low.
// Each result passes one input register, the fade curve's multiply chain
// (4 stages) and the blend tree behind it (6 stages); the corner hash and
// the dot stage run beside the fade chain.
// rst_ni clears only the valid pipeline; data registers run free.
// The result port has no back-pressure, so nothing in the pipe ever holds.
// ----------------------------------------------------------------------------
module perlin_noise_3d #(
  parameter int unsigned FRAC_BITS = pnz_pkg::PNZ_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [pnz_pkg::COORD_W-1:0]     coord_x_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]     coord_y_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]     coord_z_i,
  output logic                                   done_o,
  output logic signed [pnz_pkg::NOISE_W-1:0]     noise_value_o
);
  import pnz_pkg::*;

  logic                          accept;
  logic [PIPE_LATENCY-1:0]       valid_q;
  logic signed [COORD_W-1:0]     coord [3];
  logic signed [31:0]            coord_ext [3];
  cell_t                         cell_d [3];
  cell_t                         cell_q [3];
  logic [FRAC_BITS-1:0]          frac_d [3];
  logic [FRAC_BITS-1:0]          frac_q [4][3];
  logic [FRAC_BITS+1:0]          fade [3];
  grad_t [NUM_CORNERS-1:0]       grad;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  // floor of the coordinate, wrapped to the cell width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coord_ext[i] = 32'(coord[i]);
      cell_d[i]    = coord_ext[i][FRAC_BITS +: CELL_W];
      frac_d[i]    = coord[i][FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[PIPE_LATENCY-2:0], accept};
    end
  end

  // align the fraction with the corner hashes
  always_ff @(posedge clk_i) begin
    cell_q    <= cell_d;
    frac_q[0] <= frac_d;
    for (int s = 1; s < 4; s++) begin
      frac_q[s] <= frac_q[s-1];
    end
  end

  pnz_hash u_hash (
    .clk_i    (clk_i),
    .cell_x_i (cell_q[0]),
    .cell_y_i (cell_q[1]),
    .cell_z_i (cell_q[2]),
    .grad_o   (grad)
  );

  for (genvar g = 0; g < 3; g++) begin : g_fade
    pnz_fade #(
      .FRAC_BITS (FRAC_BITS)
    ) u_fade (
      .clk_i  (clk_i),
      .frac_i (frac_q[0][g]),
      .fade_o (fade[g])
    );
  end

  pnz_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i         (clk_i),
    .grad_i        (grad),
    .frac_x_i      (frac_q[3][0]),
    .frac_y_i      (frac_q[3][1]),
    .frac_z_i      (frac_q[3][2]),
    .fade_x_i      (fade[0]),
    .fade_y_i      (fade[1]),
    .fade_z_i      (fade[2]),
    .noise_value_o (noise_value_o)
  );

  assign done_o = valid_q[PIPE_LATENCY-1];

  a_accept_gives_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |-> ##PIPE_LATENCY done_o
  ) else $error("accepted item produced no result");

  a_done_has_item : assert property (
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(accept, PIPE_LATENCY)
  ) else $error("result without an accepted item");

  a_done_value_known : assert property (
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> !$isunknown(noise_value_o)
  ) else $error("result value unknown");

endmodule
`default_nettype wire

### test/perlin_noise_3d_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_3d_checker: scoreboard for the 3D gradient noise pipeline
// Watches the point and noise channels, computes the expected noise value
// of each accepted point and compares it with the sample that comes out.
// ----------------------------------------------------------------------------
module perlin_noise_3d_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]  coord_z_i,
  input  logic                                done_i,
  input  logic signed [pnz_pkg::NOISE_W-1:0]  noise_value_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         noise_pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import pnz_pkg::*;

  localparam int unsigned FB       = PNZ_FRAC_BITS;
  localparam longint      UNIT_Q   = longint'(1) <<< FB;
  localparam longint      HALF_Q   = longint'(1) <<< (FB - 1);

  logic signed [NOISE_W-1:0] noise_due_q [$];

  function automatic longint fade_q(input longint f);
    longint sq;
    longint cube;
    longint poly;
    sq   = (f * f + HALF_Q) >>> FB;
    cube = (sq * f + HALF_Q) >>> FB;
    poly = 10 * UNIT_Q - ((((15 * UNIT_Q) - 6 * f) * f + HALF_Q) >>> FB);
    return (cube * poly + HALF_Q) >>> FB;
  endfunction

  // Round half up: arithmetic shift of a signed value is a floor
  function automatic longint lerp_q(input longint t, input longint a, input longint b);
    return a + ((t * (b - a) + HALF_Q) >>> FB);
  endfunction

  function automatic int unsigned hash_of(input int unsigned idx);
    return 32'(PERM_ROM[idx[7:0]]);
  endfunction

  function automatic longint grad_dot(input int unsigned hash, input longint x,
                                      input longint y, input longint z);
    grad_t  h;
    longint u;
    longint v;
    h = grad_t'(hash);
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h == GRAD_ZX_A || h == GRAD_ZX_B) begin
      v = x;
    end else begin
      v = z;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_at(
    input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
    input logic [COORD_W-1:0] pz
  );
    int unsigned cx, cy, cz;
    int unsigned a, aa, ab, b, ba, bb;
    longint      x, y, z, x1, y1, z1;
    longint      fu, fv, fw;
    longint      lo, hi, r;
    // Low bits of the integer part give the wrapped cell, floor included
    cx = int'(px[FB+7:FB]);
    cy = int'(py[FB+7:FB]);
    cz = int'(pz[FB+7:FB]);
    x  = longint'(px[FB-1:0]);
    y  = longint'(py[FB-1:0]);
    z  = longint'(pz[FB-1:0]);
    x1 = x - UNIT_Q;
    y1 = y - UNIT_Q;
    z1 = z - UNIT_Q;
    fu = fade_q(x);
    fv = fade_q(y);
    fw = fade_q(z);
    a  = hash_of(cx) + cy;
    aa = hash_of(a) + cz;
    ab = hash_of(a + 1) + cz;
    b  = hash_of(cx + 1) + cy;
    ba = hash_of(b) + cz;
    bb = hash_of(b + 1) + cz;
    lo = lerp_q(fv,
                lerp_q(fu, grad_dot(hash_of(aa), x, y, z),
                           grad_dot(hash_of(ba), x1, y, z)),
                lerp_q(fu, grad_dot(hash_of(ab), x, y1, z),
                           grad_dot(hash_of(bb), x1, y1, z)));
    hi = lerp_q(fv,
                lerp_q(fu, grad_dot(hash_of(aa + 1), x, y, z1),
                           grad_dot(hash_of(ba + 1), x1, y, z1)),
                lerp_q(fu, grad_dot(hash_of(ab + 1), x, y1, z1),
                           grad_dot(hash_of(bb + 1), x1, y1, z1)));
    r = lerp_q(fw, lo, hi);
    if (r > NOISE_MAX) r = NOISE_MAX;
    if (r < NOISE_MIN) r = NOISE_MIN;
    return r[NOISE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [NOISE_W-1:0] due;
    if (!rst_ni) begin
      noise_due_q.delete();
      fail_count_o    <= 0;
      noise_pending_o <= 0;
    end else begin
      if (done_i) begin
        if (noise_due_q.size() == 0) begin
          $display("%0t: unexpected noise sample %0d", $time, noise_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = noise_due_q.pop_front();
          if (noise_value_i !== due) begin
            $display("%0t: noise_value expected %0d actual %0d",
                     $time, due, noise_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // append the expected sample at the tail
      if (start_i && !busy_i) begin
        noise_due_q.insert(noise_due_q.size(),
                           noise_at(coord_x_i, coord_y_i, coord_z_i));
      end
      noise_pending_o <= $unsigned(noise_due_q.size());
    end
  end

endmodule
`default_nettype wire

### test/perlin_noise_3d_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_3d_test: top of the 3D gradient noise testbench
// Drives directed corner points and random point streams with varying
// sender gaps; the checker beside the block predicts every sample.
// ----------------------------------------------------------------------------
module perlin_noise_3d_test;

  timeunit 1ns;
  timeprecision 1ps;

  import pnz_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_POINTS = 420;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_q;
  logic                      busy_o;
  logic signed [COORD_W-1:0] coord_x_q;
  logic signed [COORD_W-1:0] coord_y_q;
  logic signed [COORD_W-1:0] coord_z_q;
  logic                      done_o;
  logic signed [NOISE_W-1:0] noise_value_o;
  int unsigned               fail_count;
  int unsigned               noise_pending;
  int unsigned               stall_cycles;
  int unsigned               gap_pct;

  perlin_noise_3d i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_q),
    .busy_o        (busy_o),
    .coord_x_i     (coord_x_q),
    .coord_y_i     (coord_y_q),
    .coord_z_i     (coord_z_q),
    .done_o        (done_o),
    .noise_value_o (noise_value_o)
  );

  perlin_noise_3d_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_q),
    .busy_i          (busy_o),
    .coord_x_i       (coord_x_q),
    .coord_y_i       (coord_y_q),
    .coord_z_i       (coord_z_q),
    .done_i          (done_o),
    .noise_value_i   (noise_value_o),
    .fail_count_o    (fail_count),
    .noise_pending_o (noise_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_q && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] v;
    v = COORD_W'($urandom());
    case ($urandom_range(7))
      0: v[15:0] = '0;
      1: v[15:0] = '1;
      2: v[15:0] = 16'h8000;
      3: v[23:16] = $urandom_range(1) ? 8'h00 : 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  // Hold the point until the block takes it
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
    while ($urandom_range(99) < gap_pct) begin
      start_q <= 1'b0;
      @(posedge clk_i);
    end
    start_q   <= 1'b1;
    coord_x_q <= x;
    coord_y_q <= y;
    coord_z_q <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain_noise();
    start_q <= 1'b0;
    @(posedge clk_i);
    while (noise_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni    = 1'b0;
    start_q   = 1'b0;
    coord_x_q = '0;
    coord_y_q = '0;
    coord_z_q = '0;
    gap_pct   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lattice points, range ends, fraction ends and cell wrap
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_point(24'h7FFFFF, 24'h800000, 24'h000000);
    send_point(24'h800000, 24'h000000, 24'h7FFFFF);
    send_point(24'h00FFFF, 24'h000000, 24'h000000);
    send_point(24'h000000, 24'h00FFFF, 24'h000000);
    send_point(24'h000000, 24'h000000, 24'h00FFFF);
    send_point(24'h008000, 24'h008000, 24'h008000);
    send_point(24'h000001, 24'h000001, 24'h000001);
    send_point(24'h010000, 24'h020000, 24'h030000);
    send_point(24'hFF0000, 24'hFF0000, 24'hFF0000);
    send_point(24'hFF8000, 24'h008000, 24'hFF8000);
    send_point(24'h7F8000, 24'h808000, 24'h7F4000);
    send_point(24'h80FFFF, 24'h7F0001, 24'hFFFFFF);
    send_point(24'h123456, 24'hABCDEF, 24'h555555);
    send_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    send_point(24'h00C000, 24'hFF4000, 24'h004000);
    send_point(24'hFE0000, 24'h01FFFF, 24'h7E0000);
    drain_noise();

    gap_pct = 30;
    repeat (PHASE_POINTS) send_point(rand_coord(), rand_coord(), rand_coord());
    drain_noise();

    gap_pct = 52;
    repeat (PHASE_POINTS) send_point(rand_coord(), rand_coord(), rand_coord());
    drain_noise();

    gap_pct = 0;
    repeat (PHASE_POINTS) send_point(rand_coord(), rand_coord(), rand_coord());
    drain_noise();

    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (fail_count == 0 && noise_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
design/pnz_pkg.sv
design/pnz_hash.sv
design/pnz_fade.sv
design/pnz_blend.sv
design/perlin_noise_3d.sv
test/perlin_noise_3d_checker.sv
test/perlin_noise_3d_test.sv
